[rtl/core/rri_pkg.sv]
// ----------------------------------------------------------------------------
// Ray/rectangle intersection package
// Shared widths, payload structs, control struct and register index codes.
// ----------------------------------------------------------------------------
package rri_pkg;

   localparam int COORD_BITS      = 20;
   localparam int FRAC_BITS_DEF   = 10;
   localparam int PACK_BITS       = 3 * COORD_BITS;
   localparam int LEN_BITS        = 2 * COORD_BITS + 1;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = PACK_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [PACK_BITS-1:0]         packed_vec_type;

   typedef struct packed {
      coord_type origin_x;
      coord_type origin_y;
      coord_type origin_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } rri_req_type;

   typedef struct packed {
      logic                  hit;
      logic [COORD_BITS-1:0] distance;
      coord_type             point_x;
      coord_type             point_y;
      coord_type             point_z;
   } rri_rsp_type;

   // valid travels with each stage, miss collects reject reasons
   typedef struct packed {
      logic valid;
      logic miss;
   } ctl_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CORNER        = 3'd0,
      CSR_EDGE_A        = 3'd1,
      CSR_EDGE_B        = 3'd2,
      CSR_PLANE_NORMAL  = 3'd3,
      CSR_EDGE_A_LEN_SQ = 3'd4,
      CSR_EDGE_B_LEN_SQ = 3'd5,
      CSR_MIN_DISTANCE  = 3'd6
   } csr_index_type;

   function automatic coord_type lane(input packed_vec_type v, input int i);
      return coord_type'(v[i*COORD_BITS +: COORD_BITS]);
   endfunction

endpackage

[rtl/core/rri_front.sv]
// ----------------------------------------------------------------------------
// Ray/rectangle front end
// Plane dot products, sums, sign and overflow screening, divider setup.
// ----------------------------------------------------------------------------
module rri_front #(
   parameter int FRAC_BITS = rri_pkg::FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    valid_i,
   input  rri_pkg::rri_req_type    ray_i,
   input  rri_pkg::packed_vec_type corner_i,
   input  rri_pkg::packed_vec_type normal_i,
   output rri_pkg::ctl_type        ctl_o,
   output rri_pkg::rri_req_type    ray_o,
   output logic [3*rri_pkg::COORD_BITS+FRAC_BITS+2:0] rem_o,
   output logic [2*rri_pkg::COORD_BITS+1:0]           dmag_o
);
   import rri_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int DW   = CB + 1;
   localparam int PNW  = 2 * CB + 1;
   localparam int PDW  = 2 * CB;
   localparam int NUMW = 2 * CB + 3;
   localparam int DENW = 2 * CB + 2;
   localparam int AW   = 3 * CB + FRAC_BITS + 3;

   // stage 1: products
   ctl_type                 ctl1_ff, ctl1_in;
   rri_req_type             ray1_ff;
   logic signed [PNW-1:0]   pn1_ff [3];
   logic signed [PNW-1:0]   pn1_in [3];
   logic signed [PDW-1:0]   pd1_ff [3];
   logic signed [PDW-1:0]   pd1_in [3];
   // stage 2: sums
   ctl_type                 ctl2_ff;
   rri_req_type             ray2_ff;
   logic signed [NUMW-1:0]  num2_ff, num2_in;
   logic signed [DENW-1:0]  den2_ff, den2_in;
   // stage 3: magnitudes and screening
   ctl_type                 ctl3_ff, ctl3_in;
   rri_req_type             ray3_ff;
   logic [AW-1:0]           rem3_ff, rem3_in;
   logic [DENW-1:0]         dmag3_ff, dmag3_in;

   coord_type               o [3];
   coord_type               d [3];
   logic signed [DW-1:0]    diff [3];

   assign o[0] = ray_i.origin_x;
   assign o[1] = ray_i.origin_y;
   assign o[2] = ray_i.origin_z;
   assign d[0] = ray_i.dir_x;
   assign d[1] = ray_i.dir_y;
   assign d[2] = ray_i.dir_z;

   always_comb begin
      ctl1_in.valid = valid_i;
      ctl1_in.miss  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         diff[i]   = DW'(lane(corner_i, i)) - DW'(o[i]);
         pn1_in[i] = PNW'(diff[i]) * PNW'(lane(normal_i, i));
         pd1_in[i] = PDW'(d[i]) * PDW'(lane(normal_i, i));
      end
   end

   assign num2_in = NUMW'(pn1_ff[0]) + NUMW'(pn1_ff[1]) + NUMW'(pn1_ff[2]);
   assign den2_in = DENW'(pd1_ff[0]) + DENW'(pd1_ff[1]) + DENW'(pd1_ff[2]);

   always_comb begin
      logic [NUMW-1:0] nmag;
      logic [AW-1:0]   dsh;
      logic            neg_n;
      logic            neg_d;
      neg_n    = num2_ff[NUMW-1];
      neg_d    = den2_ff[DENW-1];
      nmag     = neg_n ? NUMW'(-num2_ff) : NUMW'(num2_ff);
      dmag3_in = neg_d ? DENW'(-den2_ff) : DENW'(den2_ff);
      rem3_in  = AW'(nmag) << FRAC_BITS;
      dsh      = AW'(dmag3_in) << CB;
      // parallel ray, negative t, or quotient too large to report
      ctl3_in.valid = ctl2_ff.valid;
      ctl3_in.miss  = (den2_ff == '0) || (neg_n ^ neg_d) || (rem3_in >= dsh);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (advance) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray1_ff  <= ray_i;
         pn1_ff   <= pn1_in;
         pd1_ff   <= pd1_in;
         ray2_ff  <= ray1_ff;
         num2_ff  <= num2_in;
         den2_ff  <= den2_in;
         ray3_ff  <= ray2_ff;
         rem3_ff  <= rem3_in;
         dmag3_ff <= dmag3_in;
      end
   end

   assign ctl_o  = ctl3_ff;
   assign ray_o  = ray3_ff;
   assign rem_o  = rem3_ff;
   assign dmag_o = dmag3_ff;

endmodule

[rtl/core/rri_div_step.sv]
// ----------------------------------------------------------------------------
// Divider step
// One restoring division stage: resolves a single quotient bit.
// ----------------------------------------------------------------------------
module rri_div_step #(
   parameter int FRAC_BITS = rri_pkg::FRAC_BITS_DEF,
   parameter int SHIFT     = 0
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        advance,
   input  rri_pkg::ctl_type                            ctl_i,
   input  rri_pkg::rri_req_type                        ray_i,
   input  logic [3*rri_pkg::COORD_BITS+FRAC_BITS+2:0]  rem_i,
   input  logic [2*rri_pkg::COORD_BITS+1:0]            dmag_i,
   input  logic [rri_pkg::COORD_BITS-1:0]              quo_i,
   output rri_pkg::ctl_type                            ctl_o,
   output rri_pkg::rri_req_type                        ray_o,
   output logic [3*rri_pkg::COORD_BITS+FRAC_BITS+2:0]  rem_o,
   output logic [2*rri_pkg::COORD_BITS+1:0]            dmag_o,
   output logic [rri_pkg::COORD_BITS-1:0]              quo_o
);
   import rri_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int DENW = 2 * CB + 2;
   localparam int AW   = 3 * CB + FRAC_BITS + 3;

   ctl_type         ctl_ff;
   rri_req_type     ray_ff;
   logic [AW-1:0]   rem_ff, rem_in;
   logic [DENW-1:0] dmag_ff;
   logic [CB-1:0]   quo_ff, quo_in;

   always_comb begin
      logic [AW-1:0] trial;
      trial  = AW'(dmag_i) << SHIFT;
      rem_in = rem_i;
      quo_in = quo_i;
      if (rem_i >= trial) begin
         rem_in        = rem_i - trial;
         quo_in[SHIFT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray_ff  <= ray_i;
         rem_ff  <= rem_in;
         dmag_ff <= dmag_i;
         quo_ff  <= quo_in;
      end
   end

   assign ctl_o  = ctl_ff;
   assign ray_o  = ray_ff;
   assign rem_o  = rem_ff;
   assign dmag_o = dmag_ff;
   assign quo_o  = quo_ff;

endmodule

[rtl/core/rri_back.sv]
// ----------------------------------------------------------------------------
// Ray/rectangle back end
// Hit point, edge projections, range tests and the result register.
// ----------------------------------------------------------------------------
module rri_back #(
   parameter int FRAC_BITS = rri_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  rri_pkg::ctl_type               ctl_i,
   input  rri_pkg::rri_req_type           ray_i,
   input  logic [rri_pkg::COORD_BITS-1:0] quo_i,
   input  rri_pkg::packed_vec_type        corner_i,
   input  rri_pkg::packed_vec_type        edge_a_i,
   input  rri_pkg::packed_vec_type        edge_b_i,
   input  logic [rri_pkg::LEN_BITS-1:0]   len_a_i,
   input  logic [rri_pkg::LEN_BITS-1:0]   len_b_i,
   input  logic [rri_pkg::COORD_BITS-1:0] min_dist_i,
   output logic                           rsp_valid_o,
   output rri_pkg::rri_rsp_type           rsp_o
);
   import rri_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int PTW = 2 * CB + 1;
   localparam int PW  = 2 * CB - FRAC_BITS + 2;
   localparam int OW  = PW + 1;
   localparam int QW  = OW + CB;
   localparam int SW  = QW + 2;
   localparam logic [PTW:0] HALF = (PTW+1)'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] SAT_HI = PW'((64'sd1 <<< (CB - 1)) - 64'sd1);
   localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);

   // stage 1: t times direction
   ctl_type               ctl1_ff, ctl1_in;
   rri_req_type           ray1_ff;
   logic [CB-1:0]         tq1_ff;
   logic signed [PTW-1:0] pt1_ff [3];
   logic signed [PTW-1:0] pt1_in [3];
   // stage 2: hit point and offset
   ctl_type               ctl2_ff;
   logic [CB-1:0]         tq2_ff;
   logic signed [PW-1:0]  p2_ff [3];
   logic signed [PW-1:0]  p2_in [3];
   logic signed [OW-1:0]  off2_ff [3];
   logic signed [OW-1:0]  off2_in [3];
   // stage 3: edge products
   ctl_type               ctl3_ff;
   logic [CB-1:0]         tq3_ff;
   logic signed [PW-1:0]  p3_ff [3];
   logic signed [QW-1:0]  qa3_ff [3];
   logic signed [QW-1:0]  qa3_in [3];
   logic signed [QW-1:0]  qb3_ff [3];
   logic signed [QW-1:0]  qb3_in [3];
   // stage 4: result
   ctl_type               ctl4_in;
   logic                  rsp_valid_ff;
   rri_rsp_type           rsp_ff, rsp_in;

   coord_type             o1 [3];
   coord_type             d0 [3];
   coord_type             sat [3];

   assign d0[0] = ray_i.dir_x;
   assign d0[1] = ray_i.dir_y;
   assign d0[2] = ray_i.dir_z;
   assign o1[0] = ray1_ff.origin_x;
   assign o1[1] = ray1_ff.origin_y;
   assign o1[2] = ray1_ff.origin_z;

   always_comb begin
      ctl1_in.valid = ctl_i.valid;
      ctl1_in.miss  = ctl_i.miss || (quo_i <= min_dist_i);
      for (int i = 0; i < 3; i++) begin
         pt1_in[i] = PTW'($signed({1'b0, quo_i})) * PTW'(d0[i]);
      end
   end

   always_comb begin
      logic signed [PTW:0] s [3];
      for (int i = 0; i < 3; i++) begin
         // round half up, then floor
         s[i]       = (PTW+1)'(pt1_ff[i]) + $signed(HALF);
         p2_in[i]   = PW'(s[i] >>> FRAC_BITS) + PW'(o1[i]);
         off2_in[i] = OW'(p2_in[i]) - OW'(lane(corner_i, i));
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qa3_in[i] = QW'(off2_ff[i]) * QW'(lane(edge_a_i, i));
         qb3_in[i] = QW'(off2_ff[i]) * QW'(lane(edge_b_i, i));
      end
   end

   always_comb begin
      logic signed [SW-1:0] pa;
      logic signed [SW-1:0] pb;
      logic                 out_a;
      logic                 out_b;
      logic                 hit;
      pa    = SW'(qa3_ff[0]) + SW'(qa3_ff[1]) + SW'(qa3_ff[2]);
      pb    = SW'(qb3_ff[0]) + SW'(qb3_ff[1]) + SW'(qb3_ff[2]);
      out_a = pa[SW-1] || ($unsigned(pa) > SW'(len_a_i));
      out_b = pb[SW-1] || ($unsigned(pb) > SW'(len_b_i));
      hit   = !(ctl3_ff.miss || out_a || out_b);
      for (int i = 0; i < 3; i++) begin
         if (p3_ff[i] > SAT_HI) begin
            sat[i] = coord_type'(SAT_HI);
         end else if (p3_ff[i] < SAT_LO) begin
            sat[i] = coord_type'(SAT_LO);
         end else begin
            sat[i] = coord_type'(p3_ff[i]);
         end
      end
      ctl4_in.valid   = ctl3_ff.valid;
      ctl4_in.miss    = !hit;
      rsp_in.hit      = hit;
      rsp_in.distance = hit ? tq3_ff : '0;
      rsp_in.point_x  = hit ? sat[0] : '0;
      rsp_in.point_y  = hit ? sat[1] : '0;
      rsp_in.point_z  = hit ? sat[2] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff      <= '0;
         ctl2_ff      <= '0;
         ctl3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         ctl1_ff      <= ctl1_in;
         ctl2_ff      <= ctl1_ff;
         ctl3_ff      <= ctl2_ff;
         rsp_valid_ff <= ctl4_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray1_ff <= ray_i;
         tq1_ff  <= quo_i;
         pt1_ff  <= pt1_in;
         tq2_ff  <= tq1_ff;
         p2_ff   <= p2_in;
         off2_ff <= off2_in;
         tq3_ff  <= tq2_ff;
         p3_ff   <= p2_ff;
         qa3_ff  <= qa3_in;
         qb3_ff  <= qb3_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

endmodule

[rtl/core/ray_rectangle_intersect_top.sv]
// Throughput: one transaction per cycle; the full pipeline holds while a response stalls.
// The divider is restoring and resolves one quotient bit per stage.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: geometry zero, min_distance one.
// ----------------------------------------------------------------------------
// Ray/rectangle intersection top level
// Register file, plane front end, pipelined divider and hit back end.
// ----------------------------------------------------------------------------
module ray_rectangle_intersect_top #(
   parameter int FRAC_BITS = rri_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rri_pkg::rri_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rri_pkg::rri_rsp_type               rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [rri_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rri_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import rri_pkg::*;

   localparam int CB   = COORD_BITS;
   localparam int DENW = 2 * CB + 2;
   localparam int AW   = 3 * CB + FRAC_BITS + 3;

   packed_vec_type      corner_ff;
   packed_vec_type      edge_a_ff;
   packed_vec_type      edge_b_ff;
   packed_vec_type      normal_ff;
   logic [LEN_BITS-1:0] len_a_ff;
   logic [LEN_BITS-1:0] len_b_ff;
   logic [CB-1:0]       min_dist_ff;

   logic                advance;

   ctl_type             ctl_s [CB+1];
   rri_req_type         ray_s [CB+1];
   logic [AW-1:0]       rem_s [CB+1];
   logic [DENW-1:0]     dmag_s [CB+1];
   logic [CB-1:0]       quo_s [CB+1];

   // hold the whole pipeline while a finished response is not taken
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff   <= '0;
         edge_a_ff   <= '0;
         edge_b_ff   <= '0;
         normal_ff   <= '0;
         len_a_ff    <= '0;
         len_b_ff    <= '0;
         min_dist_ff <= CB'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_CORNER:        corner_ff   <= csr_data[PACK_BITS-1:0];
            CSR_EDGE_A:        edge_a_ff   <= csr_data[PACK_BITS-1:0];
            CSR_EDGE_B:        edge_b_ff   <= csr_data[PACK_BITS-1:0];
            CSR_PLANE_NORMAL:  normal_ff   <= csr_data[PACK_BITS-1:0];
            CSR_EDGE_A_LEN_SQ: len_a_ff    <= csr_data[LEN_BITS-1:0];
            CSR_EDGE_B_LEN_SQ: len_b_ff    <= csr_data[LEN_BITS-1:0];
            CSR_MIN_DISTANCE:  min_dist_ff <= csr_data[CB-1:0];
            default: ;
         endcase
      end
   end

   rri_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_i  (req_valid),
      .ray_i    (req_data),
      .corner_i (corner_ff),
      .normal_i (normal_ff),
      .ctl_o    (ctl_s[0]),
      .ray_o    (ray_s[0]),
      .rem_o    (rem_s[0]),
      .dmag_o   (dmag_s[0])
   );

   assign quo_s[0] = '0;

   for (genvar k = 0; k < CB; k++) begin : g_div
      rri_div_step #(.FRAC_BITS(FRAC_BITS), .SHIFT(CB - 1 - k)) u_step (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctl_i   (ctl_s[k]),
         .ray_i   (ray_s[k]),
         .rem_i   (rem_s[k]),
         .dmag_i  (dmag_s[k]),
         .quo_i   (quo_s[k]),
         .ctl_o   (ctl_s[k+1]),
         .ray_o   (ray_s[k+1]),
         .rem_o   (rem_s[k+1]),
         .dmag_o  (dmag_s[k+1]),
         .quo_o   (quo_s[k+1])
      );
   end

   rri_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .ctl_i       (ctl_s[CB]),
      .ray_i       (ray_s[CB]),
      .quo_i       (quo_s[CB]),
      .corner_i    (corner_ff),
      .edge_a_i    (edge_a_ff),
      .edge_b_i    (edge_b_ff),
      .len_a_i     (len_a_ff),
      .len_b_i     (len_b_ff),
      .min_dist_i  (min_dist_ff),
      .rsp_valid_o (rsp_valid),
      .rsp_o       (rsp_data)
   );

`ifndef SYNTH
   // a miss carries an all-zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |->
         (rsp_data.distance == '0 && rsp_data.point_x == '0 &&
          rsp_data.point_y == '0 && rsp_data.point_z == '0))
      else $error("miss response with nonzero payload");

   // pipeline comes out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a hit never reports zero distance
   a_hit_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.distance != '0))
      else $error("hit with zero distance");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray/rectangle intersection testbench
// Streams rays through the block under several rectangle setups, predicts
// each response in fixed point and checks it field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
   import rri_pkg::*;

   localparam int DRAIN_CYCLES = COORD_BITS + 12;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rri_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rri_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   ray_rectangle_intersect_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the rectangle registers
   packed_vec_type rect_corner = '0, rect_edge_a = '0, rect_edge_b = '0, rect_normal = '0;
   logic [LEN_BITS-1:0] len_a_sq = '0, len_b_sq = '0;
   logic [COORD_BITS-1:0] min_t = 1;

   rri_req_type pending_rays[$];
   rri_rsp_type expected_hits[$];
   int mismatches = 0;
   bit calm = 1'b0;
   int quiet_cycles = 0;

   function automatic longint coord_at(packed_vec_type v, int i);
      coord_type c;
      c = v[i*COORD_BITS +: COORD_BITS];
      return longint'(c);
   endfunction

   function automatic longint clamp_coord(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic packed_vec_type pack3(longint x, longint y, longint z);
      coord_type cx, cy, cz;
      cx = x; cy = y; cz = z;
      return {cz, cy, cx};
   endfunction

   function automatic rri_rsp_type trace_ray(rri_req_type r);
      rri_rsp_type res;
      longint o[3], d[3], p[3];
      longint num, den, tq, pa, pb, off;
      res = '0;
      num = 0; den = 0; pa = 0; pb = 0;
      o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
      d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
      for (int i = 0; i < 3; i++) begin
         num += (coord_at(rect_corner, i) - o[i]) * coord_at(rect_normal, i);
         den += d[i] * coord_at(rect_normal, i);
      end
      if (den == 0) return res;
      tq = (num * 1024) / den;
      if (tq <= longint'(min_t)) return res;
      if (tq > 64'sd1048575) return res;
      for (int i = 0; i < 3; i++) begin
         p[i] = o[i] + ((tq * d[i] + 512) >>> 10);
         off = p[i] - coord_at(rect_corner, i);
         pa += off * coord_at(rect_edge_a, i);
         pb += off * coord_at(rect_edge_b, i);
      end
      if (pa < 0 || pa > longint'(len_a_sq)) return res;
      if (pb < 0 || pb > longint'(len_b_sq)) return res;
      res.hit = 1'b1;
      res.distance = tq[COORD_BITS-1:0];
      res.point_x = clamp_coord(p[0]);
      res.point_y = clamp_coord(p[1]);
      res.point_z = clamp_coord(p[2]);
      return res;
   endfunction

   // driver: advance when the current ray is taken or none is offered
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_hits.push_back(trace_ray(req_data));
         if (pending_rays.size() > 0 && (calm || $urandom_range(99) >= 35)) begin
            req_valid <= 1'b1;
            req_data <= pending_rays.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rri_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 35);
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               want = expected_hits.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.distance !== want.distance ||
                   rsp_data.point_x !== want.point_x || rsp_data.point_y !== want.point_y ||
                   rsp_data.point_z !== want.point_z) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_data);
               end
            end
         end
      end
   end

   // watchdog on transactions of any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_rays.size() > 0 || req_valid || expected_hits.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // keep valid high across back-to-back writes, drop it with end_config
   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_CORNER:        rect_corner = value;
         CSR_EDGE_A:        rect_edge_a = value;
         CSR_EDGE_B:        rect_edge_b = value;
         CSR_PLANE_NORMAL:  rect_normal = value;
         CSR_EDGE_A_LEN_SQ: len_a_sq = value[LEN_BITS-1:0];
         CSR_EDGE_B_LEN_SQ: len_b_sq = value[LEN_BITS-1:0];
         CSR_MIN_DISTANCE:  min_t = value[COORD_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic end_config();
      csr_valid <= 1'b0;
   endtask

   task automatic load_rect(packed_vec_type c, packed_vec_type ea, packed_vec_type eb,
                            packed_vec_type n, logic [LEN_BITS-1:0] la,
                            logic [LEN_BITS-1:0] lb, logic [COORD_BITS-1:0] mt);
      write_reg(CSR_CORNER, c);
      write_reg(CSR_EDGE_A, ea);
      write_reg(CSR_EDGE_B, eb);
      write_reg(CSR_PLANE_NORMAL, n);
      write_reg(CSR_EDGE_A_LEN_SQ, la);
      write_reg(CSR_EDGE_B_LEN_SQ, lb);
      write_reg(CSR_MIN_DISTANCE, mt);
   endtask

   task automatic add_ray(longint ox, longint oy, longint oz,
                          longint dx, longint dy, longint dz);
      rri_req_type r;
      r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
      r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
      pending_rays.push_back(r);
   endtask

   // aim at a point in or just around the rectangle, with some pure noise mixed in
   task automatic add_aimed(int count, int noise_pct);
      rri_req_type r;
      longint tgt[3], o[3], d[3];
      int u, v, sh;
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < noise_pct) begin
            r = {$urandom, $urandom, $urandom, $urandom};
            pending_rays.push_back(r);
         end else begin
            u = $urandom_range(1124) - 100;
            v = $urandom_range(1124) - 100;
            if ($urandom_range(9) == 0) u = ($urandom_range(1)) ? 0 : 1024;
            sh = $urandom_range(2);
            for (int i = 0; i < 3; i++) begin
               tgt[i] = coord_at(rect_corner, i) + ((coord_at(rect_edge_a, i) * u +
                        coord_at(rect_edge_b, i) * v) >>> 10);
               o[i] = clamp_coord(tgt[i] + longint'($urandom_range(65536)) - 32768);
               d[i] = clamp_coord(tgt[i] - o[i]);
               if (sh == 1) d[i] = d[i] >>> 1;
               if (sh == 2) d[i] = clamp_coord(d[i] * 2);
            end
            add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // defaults: zero normal, every ray is parallel
      add_ray(0, 0, 0, 0, 0, 0);
      add_ray(524287, 524287, 524287, 524287, 524287, 524287);
      add_ray(-524288, -524288, -524288, -524288, -524288, -524288);
      add_ray(1024, -1024, 0, 0, 0, -1024);
      wait_drained();

      // square on z = 0, 32 units a side
      load_rect(pack3(-16384, -16384, 0), pack3(32768, 0, 0), pack3(0, 32768, 0),
                pack3(0, 0, 1024), 41'd1 << 30, 41'd1 << 30, 1);
      end_config();
      add_ray(0, 0, 10240, 0, 0, -1024);          // straight hit at the center
      add_ray(-16384, -16384, 1024, 0, 0, -1024); // exactly on the corner
      add_ray(16384, 16384, 1024, 0, 0, -1024);   // far corner, projection equals length
      add_ray(16385, 0, 1024, 0, 0, -1024);       // just outside the first edge
      add_ray(0, -16385, 1024, 0, 0, -1024);      // just below the corner, outside edge_b
      add_ray(0, 0, 1024, 1024, 0, 0);            // parallel to the plane
      add_ray(0, 0, 1024, 0, 0, 1024);            // plane lies behind
      add_ray(0, 0, 1, 0, 0, -1024);              // t equals min_distance
      add_ray(0, 0, 2, 0, 0, -1024);              // t just beyond it
      add_ray(0, 0, 0, 0, 0, -1024);              // origin on the plane
      add_ray(0, 0, 512000, 0, 0, -1);            // t overflows
      add_ray(0, 0, 1023, 0, 0, -1);              // largest whole-unit t that fits
      add_aimed(350, 20);
      wait_drained();

      // rectangle near the coordinate limit, hit points saturate
      load_rect(pack3(500 * 1024, 100 * 1024, 20480), pack3(40960, 0, 0), pack3(0, 8192, 0),
                pack3(0, 0, -1024), 41'd40960 * 41'd40960, 41'd8192 * 41'd8192, 512);
      end_config();
      add_ray(520 * 1024, 104 * 1024, 0, 0, 0, 1024);
      add_ray(510 * 1024, 104 * 1024, 20480 - 512, 0, 0, 1024);
      add_aimed(250, 15);
      wait_drained();

      // tilted rectangle, no idling on either side
      calm = 1'b1;
      load_rect(pack3(0, 0, -8192), pack3(8192, -8192, 0), pack3(0, 0, 16384),
                pack3(1024, 1024, 0), 41'd1 << 27, 41'd1 << 28, 0);
      end_config();
      add_aimed(250, 10);
      wait_drained();
      calm = 1'b0;

      // all ones in every register, then an index beyond the register file
      load_rect('1, '1, '1, '1, '1, '1, '1);
      write_reg(csr_index_type'(3'd7), {$urandom, $urandom});
      end_config();
      add_aimed(100, 60);
      wait_drained();

      // random geometry
      load_rect({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                $urandom_range(2048));
      end_config();
      add_aimed(100, 50);
      wait_drained();

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

[sim.f]
rtl/core/rri_pkg.sv
rtl/core/rri_front.sv
rtl/core/rri_div_step.sv
rtl/core/rri_back.sv
rtl/core/ray_rectangle_intersect_top.sv
verif/testbench.sv
